// ----- hdl/tlc_pkg.sv -----
// Shared types, register map and reset constants of the traffic light controller.
package tlc_pkg;

	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_PHASE_A   = 3'd0,
		REG_PHASE_B   = 3'd1,
		REG_YELLOW    = 3'd2,
		REG_MANUAL_CD = 3'd3,
		REG_PATTERNS  = 3'd4
	} tlc_reg_t;

	localparam logic [6:0]  PHASE_A_RST   = 7'd23;
	localparam logic [6:0]  PHASE_B_RST   = 7'd15;
	localparam logic [3:0]  YELLOW_RST    = 4'd3;
	localparam logic [3:0]  MANUAL_CD_RST = 4'd3;
	localparam logic [23:0] PATTERNS_RST  = 24'h38CC61;

	localparam logic [5:0] LAMP_R1 = 6'b000001;
	localparam logic [5:0] LAMP_Y1 = 6'b000010;
	localparam logic [5:0] LAMP_G1 = 6'b000100;
	localparam logic [5:0] LAMP_R2 = 6'b001000;
	localparam logic [5:0] LAMP_Y2 = 6'b010000;
	localparam logic [5:0] LAMP_G2 = 6'b100000;

	typedef struct packed {
		logic [6:0]  phase_a_ticks;
		logic [6:0]  phase_b_ticks;
		logic [3:0]  yellow_ticks;
		logic [3:0]  manual_countdown;
		logic [23:0] manual_patterns;
	} tlc_cfg_t;

	typedef struct packed {
		logic [5:0] lamps;
		logic [3:0] dir1_tens;
		logic [3:0] dir1_ones;
		logic [3:0] dir2_tens;
		logic [3:0] dir2_ones;
		logic       manual_active;
	} tlc_result_t;

endpackage

// ----- hdl/tlc_if.sv -----
// Valid/ready channel interfaces for tick words and result words.
interface tlc_tick_if;
	logic valid;
	logic ready;
	logic manual_switch;
	logic step_button;

	modport source (output valid, output manual_switch, output step_button, input ready);
	modport sink (input valid, input manual_switch, input step_button, output ready);
endinterface

interface tlc_result_if;
	logic       valid;
	logic       ready;
	logic [5:0] lamps;
	logic [3:0] dir1_tens;
	logic [3:0] dir1_ones;
	logic [3:0] dir2_tens;
	logic [3:0] dir2_ones;
	logic       manual_active;

	modport source (output valid, output lamps, output dir1_tens, output dir1_ones,
		output dir2_tens, output dir2_ones, output manual_active, input ready);
	modport sink (input valid, input lamps, input dir1_tens, input dir1_ones,
		input dir2_tens, input dir2_ones, input manual_active, output ready);
endinterface

// ----- hdl/traffic_light_controller.sv -----
// Top level: tick input register, controller core, result register and APB registers.
// Tick words go through the input register; result words wait in the result register.
// Throughput: one tick word per cycle without stalls; state update is one tlc_core pass.
// The result register lets a new tick enter while a finished word still waits downstream.
// Reset (arst_n low, asynchronous): pipeline empty, phase A with the phase A reset length,
// automatic mode, pattern 0, and all configuration registers at their reset values.
module traffic_light_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	tlc_tick_if.sink                    tick,
	tlc_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tlc_pkg::PADDR_W-1:0] paddr,
	input  logic [tlc_pkg::PDATA_W-1:0] pwdata,
	output logic [tlc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	tlc_pkg::tlc_cfg_t    cfg;
	tlc_pkg::tlc_result_t core_res;
	tlc_pkg::tlc_result_t res_q;

	logic valid_s1;
	logic sw_s1;
	logic btn_s1;
	logic out_valid_q;
	logic advance;

	assign pready     = 1'b1;
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	tlc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tlc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.manual_switch (sw_s1),
		.step_button   (btn_s1),
		.cfg           (cfg),
		.res           (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			sw_s1  <= tick.manual_switch;
			btn_s1 <= tick.step_button;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.lamps         = res_q.lamps;
	assign result.dir1_tens     = res_q.dir1_tens;
	assign result.dir1_ones     = res_q.dir1_ones;
	assign result.dir2_tens     = res_q.dir2_tens;
	assign result.dir2_ones     = res_q.dir2_ones;
	assign result.manual_active = res_q.manual_active;

	// An accepted word always lands in the input stage.
	a_tick_lands: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> valid_s1)
		else $error("accepted tick word did not reach the input stage");

	// A word waiting in the input stage moves on once the result side is free.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |-> advance)
		else $error("input stage stalled with an empty result register");

	// In automatic mode exactly one direction is red.
	a_one_red: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.manual_active |-> $onehot({result.lamps[0], result.lamps[3]}))
		else $error("automatic mode result without exactly one red direction");

	// In manual mode both countdowns agree.
	a_manual_same: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.manual_active |->
			(result.dir1_tens == result.dir2_tens) && (result.dir1_ones == result.dir2_ones))
		else $error("manual mode countdowns differ");

endmodule

// ----- hdl/tlc_regs.sv -----
// APB configuration register file of the traffic light controller.
module tlc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlc_pkg::PADDR_W-1:0]   paddr,
	input  logic [tlc_pkg::PDATA_W-1:0]   pwdata,
	output logic [tlc_pkg::PDATA_W-1:0]   prdata,
	output tlc_pkg::tlc_cfg_t             cfg
);

	tlc_pkg::tlc_cfg_t cfg_q;
	tlc_pkg::tlc_reg_t sel;
	logic              wr_en;

	assign sel   = tlc_pkg::tlc_reg_t'(paddr[tlc_pkg::PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_a_ticks    <= tlc_pkg::PHASE_A_RST;
			cfg_q.phase_b_ticks    <= tlc_pkg::PHASE_B_RST;
			cfg_q.yellow_ticks     <= tlc_pkg::YELLOW_RST;
			cfg_q.manual_countdown <= tlc_pkg::MANUAL_CD_RST;
			cfg_q.manual_patterns  <= tlc_pkg::PATTERNS_RST;
		end else if (wr_en) begin
			case (sel)
				tlc_pkg::REG_PHASE_A:   cfg_q.phase_a_ticks    <= pwdata[6:0];
				tlc_pkg::REG_PHASE_B:   cfg_q.phase_b_ticks    <= pwdata[6:0];
				tlc_pkg::REG_YELLOW:    cfg_q.yellow_ticks     <= pwdata[3:0];
				tlc_pkg::REG_MANUAL_CD: cfg_q.manual_countdown <= pwdata[3:0];
				tlc_pkg::REG_PATTERNS:  cfg_q.manual_patterns  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			tlc_pkg::REG_PHASE_A:   prdata = {25'd0, cfg_q.phase_a_ticks};
			tlc_pkg::REG_PHASE_B:   prdata = {25'd0, cfg_q.phase_b_ticks};
			tlc_pkg::REG_YELLOW:    prdata = {28'd0, cfg_q.yellow_ticks};
			tlc_pkg::REG_MANUAL_CD: prdata = {28'd0, cfg_q.manual_countdown};
			tlc_pkg::REG_PATTERNS:  prdata = {8'd0, cfg_q.manual_patterns};
			default:                prdata = '0;
		endcase
	end

endmodule

// ----- hdl/tlc_core.sv -----
// Controller state and the per-tick lamp and countdown logic.
module tlc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic                  manual_switch,
	input  logic                  step_button,
	input  tlc_pkg::tlc_cfg_t     cfg,
	output tlc_pkg::tlc_result_t  res
);

	logic       in_manual_q, in_manual_d;
	logic       phase_b_q, phase_b_d;
	logic [6:0] ticks_left_q, ticks_left_d;
	logic [1:0] pidx_q, pidx_d;
	logic       holding_q, holding_d;
	logic [3:0] hold_left_q, hold_left_d;

	logic [5:0] lamps;
	logic [6:0] d1, d2;
	logic [6:0] other;
	logic       yellow;

	function automatic logic [5:0] pattern_of(input logic [23:0] p, input logic [1:0] i);
		case (i)
			2'd0:    pattern_of = p[5:0];
			2'd1:    pattern_of = p[11:6];
			2'd2:    pattern_of = p[17:12];
			default: pattern_of = p[23:18];
		endcase
	endfunction

	// Tens digit by reciprocal multiply: (v * 103) >> 10 is exact for v up to 99.
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [6:0]  s;
		logic [13:0] prod;
		logic [3:0]  t;
		logic [6:0]  o;
		s      = (v > 7'd99) ? 7'd99 : v;
		prod   = 14'(s) * 14'd103;
		t      = prod[13:10];
		o      = s - 7'(t) * 7'd10;
		to_bcd = {t, o[3:0]};
	endfunction

	always_comb begin
		in_manual_d  = in_manual_q;
		phase_b_d    = phase_b_q;
		ticks_left_d = ticks_left_q;
		pidx_d       = pidx_q;
		holding_d    = holding_q;
		hold_left_d  = hold_left_q;
		lamps        = '0;
		d1           = '0;
		d2           = '0;
		yellow       = (ticks_left_q <= 7'(cfg.yellow_ticks));
		other        = yellow ? ticks_left_q : ticks_left_q - 7'(cfg.yellow_ticks);

		if (manual_switch) begin
			in_manual_d = 1'b1;
			if (holding_q) begin
				// The current pattern stays up through the last countdown tick.
				d1    = 7'(hold_left_q);
				lamps = pattern_of(cfg.manual_patterns, pidx_q);
				if (hold_left_q == 4'd0) begin
					holding_d = 1'b0;
					pidx_d    = pidx_q + 2'd1;
				end else begin
					hold_left_d = hold_left_q - 4'd1;
				end
			end else if (step_button) begin
				d1    = 7'(cfg.manual_countdown);
				lamps = pattern_of(cfg.manual_patterns, pidx_q + 2'd1);
				if (cfg.manual_countdown == 4'd0) begin
					pidx_d = pidx_q + 2'd2;
				end else begin
					pidx_d      = pidx_q + 2'd1;
					holding_d   = 1'b1;
					hold_left_d = cfg.manual_countdown - 4'd1;
				end
			end else begin
				lamps = pattern_of(cfg.manual_patterns, pidx_q);
			end
			d2 = d1;
		end else begin
			if (in_manual_q) begin
				in_manual_d = 1'b0;
				pidx_d      = '0;
				holding_d   = 1'b0;
				hold_left_d = '0;
			end
			if (!phase_b_q) begin
				lamps = tlc_pkg::LAMP_R1 | (yellow ? tlc_pkg::LAMP_Y2 : tlc_pkg::LAMP_G2);
				d1    = ticks_left_q;
				d2    = other;
			end else begin
				lamps = tlc_pkg::LAMP_R2 | (yellow ? tlc_pkg::LAMP_Y1 : tlc_pkg::LAMP_G1);
				d1    = other;
				d2    = ticks_left_q;
			end
			if (ticks_left_q <= 7'd1) begin
				phase_b_d    = !phase_b_q;
				ticks_left_d = phase_b_q ? cfg.phase_a_ticks : cfg.phase_b_ticks;
			end else begin
				ticks_left_d = ticks_left_q - 7'd1;
			end
		end
	end

	assign res.lamps                    = lamps;
	assign {res.dir1_tens, res.dir1_ones} = to_bcd(d1);
	assign {res.dir2_tens, res.dir2_ones} = to_bcd(d2);
	assign res.manual_active            = in_manual_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_manual_q  <= 1'b0;
			phase_b_q    <= 1'b0;
			ticks_left_q <= tlc_pkg::PHASE_A_RST;
			pidx_q       <= '0;
			holding_q    <= 1'b0;
			hold_left_q  <= '0;
		end else if (step_en) begin
			in_manual_q  <= in_manual_d;
			phase_b_q    <= phase_b_d;
			ticks_left_q <= ticks_left_d;
			pidx_q       <= pidx_d;
			holding_q    <= holding_d;
			hold_left_q  <= hold_left_d;
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the traffic light controller: random tick words against a predictor.

class lamp_scoreboard;
	tlc_pkg::tlc_cfg_t    cfg;
	logic                 in_manual;
	logic                 phase_b;
	logic                 step_on;
	logic [6:0]           left;
	logic [1:0]           pat_idx;
	logic [3:0]           hold;
	tlc_pkg::tlc_result_t words_due[$];
	int                   errors;

	function new();
		cfg.phase_a_ticks    = tlc_pkg::PHASE_A_RST;
		cfg.phase_b_ticks    = tlc_pkg::PHASE_B_RST;
		cfg.yellow_ticks     = tlc_pkg::YELLOW_RST;
		cfg.manual_countdown = tlc_pkg::MANUAL_CD_RST;
		cfg.manual_patterns  = tlc_pkg::PATTERNS_RST;
		in_manual = 1'b0;
		phase_b   = 1'b0;
		step_on   = 1'b0;
		left      = tlc_pkg::PHASE_A_RST;
		pat_idx   = 2'd0;
		hold      = 4'd0;
		errors    = 0;
	endfunction

	function void report(string msg);
		if (errors < 100)
			$display("MISMATCH: %s", msg);
		errors++;
	endfunction

	// Stores a register write and returns the value that a read should give back.
	function logic [31:0] apply_write(tlc_pkg::tlc_reg_t r, logic [31:0] v);
		logic [31:0] field;
		field = '0;
		case (r)
			tlc_pkg::REG_PHASE_A: begin
				cfg.phase_a_ticks = v[6:0];
				field[6:0] = v[6:0];
			end
			tlc_pkg::REG_PHASE_B: begin
				cfg.phase_b_ticks = v[6:0];
				field[6:0] = v[6:0];
			end
			tlc_pkg::REG_YELLOW: begin
				cfg.yellow_ticks = v[3:0];
				field[3:0] = v[3:0];
			end
			tlc_pkg::REG_MANUAL_CD: begin
				cfg.manual_countdown = v[3:0];
				field[3:0] = v[3:0];
			end
			tlc_pkg::REG_PATTERNS: begin
				cfg.manual_patterns = v[23:0];
				field[23:0] = v[23:0];
			end
			default: ;
		endcase
		return field;
	endfunction

	function logic [5:0] lamp_pattern(logic [1:0] idx);
		return cfg.manual_patterns[int'(idx) * 6 +: 6];
	endfunction

	function logic [7:0] to_bcd(logic [6:0] v);
		logic [6:0] s;
		logic [3:0] t;
		logic [3:0] o;
		s = (v > 7'd99) ? 7'd99 : v;
		t = 4'(s / 7'd10);
		o = 4'(s % 7'd10);
		return {t, o};
	endfunction

	function tlc_pkg::tlc_result_t next_display(logic sw, logic btn);
		tlc_pkg::tlc_result_t r;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [6:0]  other;
		logic [3:0]  shown;
		logic        yel;
		r = '0;
		if (sw) begin
			in_manual = 1'b1;
			shown = 4'd0;
			if (step_on) begin
				shown = hold;
				if (hold == 4'd0) begin
					step_on = 1'b0;
					pat_idx = pat_idx + 2'd1;
				end else begin
					hold = hold - 4'd1;
				end
				// The last tick of a step still shows the yellow pattern.
				r.lamps = lamp_pattern(shown == 4'd0 ? pat_idx - 2'd1 : pat_idx);
			end else if (btn) begin
				pat_idx = pat_idx + 2'd1;
				shown = cfg.manual_countdown;
				r.lamps = lamp_pattern(pat_idx);
				if (shown == 4'd0) begin
					pat_idx = pat_idx + 2'd1;
				end else begin
					step_on = 1'b1;
					hold = shown - 4'd1;
				end
			end else begin
				r.lamps = lamp_pattern(pat_idx);
			end
			d1 = {3'd0, shown};
			d2 = {3'd0, shown};
		end else begin
			if (in_manual) begin
				in_manual = 1'b0;
				pat_idx = 2'd0;
				step_on = 1'b0;
				hold = 4'd0;
			end
			yel = left <= {3'd0, cfg.yellow_ticks};
			other = yel ? left : left - {3'd0, cfg.yellow_ticks};
			if (!phase_b) begin
				r.lamps = tlc_pkg::LAMP_R1 | (yel ? tlc_pkg::LAMP_Y2 : tlc_pkg::LAMP_G2);
				d1 = left;
				d2 = other;
			end else begin
				r.lamps = tlc_pkg::LAMP_R2 | (yel ? tlc_pkg::LAMP_Y1 : tlc_pkg::LAMP_G1);
				d1 = other;
				d2 = left;
			end
			if (left <= 7'd1) begin
				phase_b = !phase_b;
				left = phase_b ? cfg.phase_b_ticks : cfg.phase_a_ticks;
			end else begin
				left = left - 7'd1;
			end
		end
		{r.dir1_tens, r.dir1_ones} = to_bcd(d1);
		{r.dir2_tens, r.dir2_ones} = to_bcd(d2);
		r.manual_active = in_manual;
		return r;
	endfunction

	function void note_tick(logic sw, logic btn);
		words_due.push_back(next_display(sw, btn));
	endfunction

	function int pending();
		return words_due.size();
	endfunction

	function void compare_field(string name, int got, int want);
		if (got != want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endfunction

	function void check_result(tlc_pkg::tlc_result_t got);
		tlc_pkg::tlc_result_t want;
		if (words_due.size() == 0) begin
			report($sformatf("result word %h arrived with none due", got));
			return;
		end
		want = words_due.pop_front();
		compare_field("lamps", int'(got.lamps), int'(want.lamps));
		compare_field("dir1_tens", int'(got.dir1_tens), int'(want.dir1_tens));
		compare_field("dir1_ones", int'(got.dir1_ones), int'(want.dir1_ones));
		compare_field("dir2_tens", int'(got.dir2_tens), int'(want.dir2_tens));
		compare_field("dir2_ones", int'(got.dir2_ones), int'(want.dir2_ones));
		compare_field("manual_active", int'(got.manual_active), int'(want.manual_active));
	endfunction
endclass

module tb;
	localparam int LIMIT = 400000;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [tlc_pkg::PADDR_W-1:0]  paddr;
	logic [tlc_pkg::PDATA_W-1:0]  pwdata;
	logic [tlc_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;
	logic                         calm;
	int                           stall_left;
	int                           cycles;
	lamp_scoreboard               sb;

	tlc_tick_if   tck();
	tlc_result_if res();

	traffic_light_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tck),
		.result(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one; none at all while calm.
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			res.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			res.ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left <= gap_len();
		end
	end

	always @(posedge clk) begin
		tlc_pkg::tlc_result_t word;
		if (res.valid && res.ready) begin
			word.lamps         = res.lamps;
			word.dir1_tens     = res.dir1_tens;
			word.dir1_ones     = res.dir1_ones;
			word.dir2_tens     = res.dir2_tens;
			word.dir2_ones     = res.dir2_ones;
			word.manual_active = res.manual_active;
			sb.check_result(word);
		end
	end

	// Valid stays high across back-to-back words and is lowered only ahead of a gap.
	task automatic send_tick(input logic sw, input logic btn);
		int g;
		g = gap_len();
		if (g > 0) begin
			tck.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		tck.valid <= 1'b1;
		tck.manual_switch <= sw;
		tck.step_button <= btn;
		do @(posedge clk); while (!tck.ready);
		sb.note_tick(sw, btn);
	endtask

	task automatic drain();
		tck.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input tlc_pkg::tlc_reg_t r, input logic [31:0] v);
		logic [31:0] want;
		logic [31:0] got;
		want = sb.apply_write(r, v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want)
			sb.report($sformatf("register %s read %h expected %h", r.name(), got, want));
	endtask

	// Upper bits beyond the field are filled with noise; the block must drop them.
	function automatic logic [31:0] with_noise(input logic [31:0] f, input int w);
		logic [31:0] n;
		n = $urandom();
		return (n << w) | f;
	endfunction

	task automatic load_settings(input logic [6:0] pa, input logic [6:0] pb,
		input logic [3:0] yt, input logic [3:0] mc, input logic [23:0] pat);
		drain();
		repeat (4) @(posedge clk);
		write_reg(tlc_pkg::REG_PHASE_A, with_noise({25'd0, pa}, 7));
		write_reg(tlc_pkg::REG_PHASE_B, with_noise({25'd0, pb}, 7));
		write_reg(tlc_pkg::REG_YELLOW, with_noise({28'd0, yt}, 4));
		write_reg(tlc_pkg::REG_MANUAL_CD, with_noise({28'd0, mc}, 4));
		write_reg(tlc_pkg::REG_PATTERNS, with_noise({8'd0, pat}, 24));
	endtask

	function automatic logic [6:0] rand_len();
		if ($urandom_range(0, 4) != 0)
			return 7'($urandom_range(0, 12));
		return 7'($urandom_range(0, 127));
	endfunction

	// Stretches of automatic and manual running, with some fully random noise mixed in.
	task automatic run_traffic(input int n);
		int done;
		int kind;
		int seg;
		logic sw;
		logic btn;
		done = 0;
		while (done < n) begin
			kind = $urandom_range(0, 9);
			seg = $urandom_range(1, 40);
			for (int i = 0; i < seg && done < n; i++) begin
				if (kind < 5) begin
					sw = 1'b0;
					btn = 1'($urandom_range(0, 1));
				end else if (kind < 9) begin
					sw = 1'b1;
					btn = ($urandom_range(0, 3) == 0);
				end else begin
					sw = 1'($urandom_range(0, 1));
					btn = 1'($urandom_range(0, 1));
				end
				send_tick(sw, btn);
				done++;
				if (done == n / 2)
					drain();
			end
		end
	endtask

	initial begin
		logic [1:0] script [0:24] = '{
			2'b00, 2'b01, 2'b00, 2'b01, 2'b10, 2'b11, 2'b11, 2'b10, 2'b10, 2'b10,
			2'b11, 2'b10, 2'b00, 2'b00, 2'b10, 2'b11, 2'b10, 2'b10, 2'b10, 2'b10,
			2'b11, 2'b10, 2'b10, 2'b10, 2'b01
		};
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		calm = 1'b0;
		stall_left = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tck.valid = 1'b0;
		tck.manual_switch = 1'b0;
		tck.step_button = 1'b0;
		res.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: steps, a press during a step, release mid-step and pattern wrap.
		foreach (script[i])
			send_tick(script[i][1], script[i][0]);
		run_traffic(100);

		// Zero and one tick phases, no yellow, manual countdown of zero.
		calm = 1'b1;
		load_settings(7'd0, 7'd1, 4'd0, 4'd0, 24'($urandom()));
		run_traffic(100);

		// Longest counts saturate the display; every lamp on in manual mode.
		calm = 1'b0;
		load_settings(7'd127, 7'd127, 4'd15, 4'd15, 24'hFFFFFF);
		run_traffic(100);

		// Yellow covering each whole phase.
		load_settings(7'd5, 7'd3, 4'd9, 4'd9, 24'd0);
		run_traffic(100);

		load_settings(7'd2, 7'd99, 4'd1, 4'd1, 24'($urandom()));
		run_traffic(100);

		repeat (3) begin
			calm = ($urandom_range(0, 3) == 0);
			load_settings(rand_len(), rand_len(), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), 24'($urandom()));
			run_traffic(100);
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
